// File: rtl/csc_pkg.sv
// Package with the filter, color and register codes of the color sensor classifier.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  typedef logic [1:0] filter_t;
  typedef logic [1:0] color_t;

  localparam filter_t SelClear = 2'd0;
  localparam filter_t SelGreen = 2'd1;
  localparam filter_t SelRed   = 2'd2;
  localparam filter_t SelBlue  = 2'd3;

  localparam color_t ColorWhite = 2'd0;
  localparam color_t ColorRed   = 2'd1;
  localparam color_t ColorGreen = 2'd2;
  localparam color_t ColorBlue  = 2'd3;

  localparam int ThreshW  = 16;
  localparam int RunW     = 4;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegWhiteThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] RegStableRuns     = 1'd1;

  localparam logic [ThreshW-1:0] WhiteThresholdReset = 16'd100;
  localparam logic [RunW-1:0]    StableRunsReset     = 4'd5;
  localparam logic [RunW-1:0]    RunMax              = 4'd15;

endpackage

`default_nettype wire

// File: rtl/color_sensor_classifier_unit.sv
// Color sensor classifier: filter sequencer, color classification and debounce.
//
// The input channel carries one period count per transaction, measured under
// the filter that the previous result selected. The filters step through
// clear, green, red and blue; the blue reading completes a round, classifies
// the color and runs the debounce that drives verified_color_o.
// Every accepted transaction gives exactly one result transaction with the
// select lines for the next filter, the classified flag, the raw color of the
// round and the debounced color.
// A transaction is accepted into an input register and its result is loaded
// from there into the output register. One transaction per cycle is sustained
// while the receiver does not stall; the path from input register to output
// register is four count compares and a 4-bit counter.
// When the receiver stalls, the output register holds its result and the
// input register still takes one transaction; in_stall_o rises only while both
// are full. Reset clears the counts and the debounce state, selects the clear
// filter and loads the register reset values. Configuration writes are taken
// at any edge with cfg_we_i high.
`timescale 1ns / 1ps
`default_nettype none

module color_sensor_classifier_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [csc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [csc_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]          sample_count_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 select_s2_o,
  output logic                                 select_s3_o,
  output logic                                 classified_o,
  output csc_pkg::color_t                      raw_color_o,
  output csc_pkg::color_t                      verified_color_o
);
  import csc_pkg::*;

  localparam int CmpW = (SAMPLE_BITS > ThreshW) ? SAMPLE_BITS : ThreshW;

  logic [ThreshW-1:0]     white_threshold_q;
  logic [RunW-1:0]        stable_runs_q;

  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  filter_t                filter_sel_q, filter_sel_d;
  logic [SAMPLE_BITS-1:0] clear_cnt_q, green_cnt_q, red_cnt_q;
  color_t                 candidate_q, candidate_d;
  logic [RunW-1:0]        run_length_q, run_length_d;
  color_t                 stable_color_q, stable_color_d;

  logic                   out_valid_q;
  logic                   s2_q, s3_q, classified_q;
  color_t                 raw_q;

  logic                   advance;
  logic                   step;
  logic                   is_blue;
  color_t                 raw_d;
  logic                   s2_d, s3_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign is_blue    = (filter_sel_q == SelBlue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_threshold_q <= WhiteThresholdReset;
      stable_runs_q     <= StableRunsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWhiteThreshold: white_threshold_q <= cfg_data_i[ThreshW-1:0];
        RegStableRuns:     stable_runs_q     <= cfg_data_i[RunW-1:0];
        default:           stable_runs_q     <= stable_runs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      sample_q <= sample_count_i;
    end
  end

  always_comb begin
    raw_d          = ColorWhite;
    candidate_d    = candidate_q;
    run_length_d   = run_length_q;
    stable_color_d = stable_color_q;
    if (is_blue) begin
      if (CmpW'(clear_cnt_q) > CmpW'(white_threshold_q)) begin
        raw_d = ColorWhite;
      end else if (red_cnt_q > sample_q && red_cnt_q > green_cnt_q) begin
        raw_d = ColorRed;
      end else if (green_cnt_q >= sample_q) begin
        raw_d = ColorGreen;
      end else begin
        raw_d = ColorBlue;
      end
      if (raw_d == candidate_q) begin
        if (run_length_q >= stable_runs_q) begin
          stable_color_d = raw_d;
        end else if (run_length_q < RunMax) begin
          run_length_d = run_length_q + RunW'(1);
        end
      end else begin
        candidate_d  = raw_d;
        run_length_d = RunW'(1);
      end
    end
    filter_sel_d = filter_sel_q + filter_t'(1);
    s2_d = (filter_sel_d == SelClear) || (filter_sel_d == SelGreen);
    s3_d = (filter_sel_d == SelGreen) || (filter_sel_d == SelBlue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_sel_q   <= SelClear;
      clear_cnt_q    <= '0;
      green_cnt_q    <= '0;
      red_cnt_q      <= '0;
      candidate_q    <= ColorWhite;
      run_length_q   <= '0;
      stable_color_q <= ColorWhite;
    end else if (step) begin
      filter_sel_q   <= filter_sel_d;
      candidate_q    <= candidate_d;
      run_length_q   <= run_length_d;
      stable_color_q <= stable_color_d;
      unique case (filter_sel_q)
        SelClear: clear_cnt_q <= sample_q;
        SelGreen: green_cnt_q <= sample_q;
        SelRed:   red_cnt_q   <= sample_q;
        SelBlue:  red_cnt_q   <= red_cnt_q;
        default:  red_cnt_q   <= red_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s2_q         <= s2_d;
      s3_q         <= s3_d;
      classified_q <= is_blue;
      raw_q        <= raw_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign select_s2_o      = s2_q;
  assign select_s3_o      = s3_q;
  assign classified_o     = classified_q;
  assign raw_color_o      = raw_q;
  assign verified_color_o = stable_color_q;

  a_round_ends_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && classified_o) |-> (select_s2_o && !select_s3_o))
    else $error("classified result does not select the clear filter");

  a_verified_changes_on_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stable_color_q != $past(stable_color_q)) |->
      $past(step && filter_sel_q == SelBlue))
    else $error("verified color changed outside a classification");

  a_stall_needs_full_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  a_raw_zero_when_unclassified: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !classified_o) |-> (raw_color_o == ColorWhite))
    else $error("raw color set without a classification");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for the color sensor classifier: directed table, random rounds, scoreboard.
`timescale 1ns / 1ps

module tb;
  import csc_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int PhaseItems = 64;
  localparam int NumPhases = 8;
  localparam int DirectedRows = 24;

  typedef struct packed {
    logic   s2;
    logic   s3;
    logic   classified;
    color_t raw;
    color_t verified;
  } result_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        typed;
    result_t     res;
  } stim_row_t;

  localparam result_t NoRes = '0;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [15:0]         sample;
  logic                out_valid;
  logic                out_stall;
  logic                s2;
  logic                s3;
  logic                classified;
  color_t              raw_color;
  color_t              verified_color;

  filter_t       filt_sel_q;
  logic [15:0]   filt_count_q [4];
  color_t        cand_color_q;
  logic [RunW-1:0] run_len_q;
  color_t        stable_color_q;
  logic [15:0]   white_thresh_q;
  logic [RunW-1:0] stable_runs_q;

  result_t   pending_results [$];
  stim_row_t directed_rows [DirectedRows];
  int        round_plan [4];
  color_t    target_color;
  int        accepted_count;
  int        error_count;
  int        round_count;
  int        verified_changes;
  int        setting_count;
  color_t    last_verified;
  bit        tx_gaps;
  bit        rx_gaps;

  color_sensor_classifier_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_count_i   (sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .select_s2_o      (s2),
    .select_s3_o      (s3),
    .classified_o     (classified),
    .raw_color_o      (raw_color),
    .verified_color_o (verified_color)
  );

  always #(HalfPeriod) clk = ~clk;

  task automatic predict_sample(input logic [15:0] v, output result_t r);
    color_t found;
    found = ColorWhite;
    r = NoRes;
    filt_count_q[filt_sel_q] = v;
    r.classified = (filt_sel_q == SelBlue);
    if (filt_sel_q == SelBlue) begin
      if (filt_count_q[SelClear] > white_thresh_q) begin
        found = ColorWhite;
      end else if (filt_count_q[SelRed] > filt_count_q[SelBlue] &&
                   filt_count_q[SelRed] > filt_count_q[SelGreen]) begin
        found = ColorRed;
      end else if (filt_count_q[SelGreen] >= filt_count_q[SelBlue]) begin
        found = ColorGreen;
      end else begin
        found = ColorBlue;
      end
      if (found == cand_color_q) begin
        if (run_len_q >= stable_runs_q) begin
          stable_color_q = found;
        end else if (run_len_q < RunMax) begin
          run_len_q = run_len_q + 1'b1;
        end
      end else begin
        cand_color_q = found;
        run_len_q = RunW'(1);
      end
    end
    filt_sel_q = filt_sel_q + 1'b1;
    r.s2 = (filt_sel_q == SelClear) || (filt_sel_q == SelGreen);
    r.s3 = (filt_sel_q == SelGreen) || (filt_sel_q == SelBlue);
    r.raw = found;
    r.verified = stable_color_q;
  endtask

  // Plans a whole four-filter round at each clear slot, mostly aimed at one color.
  task automatic pick_sample(output logic [15:0] v);
    int kind;
    int hi;
    int thr;
    thr = int'(white_thresh_q);
    if (accepted_count % 4 == 0) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < 7) target_color = color_t'($urandom_range(0, 3));
      if (kind == 0) begin
        for (int i = 0; i < 4; i++) round_plan[i] = $urandom_range(0, 65535);
      end else if (kind == 1) begin
        for (int i = 0; i < 4; i++) round_plan[i] = $urandom_range(0, 3);
      end else begin
        hi = $urandom_range(1, 65535);
        round_plan[SelClear] = $urandom_range(0, thr);
        case (target_color)
          ColorWhite: begin
            round_plan[SelClear] = (thr == 65535) ? 65535 : $urandom_range(thr + 1, 65535);
            round_plan[SelGreen] = $urandom_range(0, 65535);
            round_plan[SelRed]   = $urandom_range(0, 65535);
            round_plan[SelBlue]  = $urandom_range(0, 65535);
          end
          ColorRed: begin
            round_plan[SelRed]   = hi;
            round_plan[SelGreen] = $urandom_range(0, hi - 1);
            round_plan[SelBlue]  = $urandom_range(0, hi - 1);
          end
          ColorGreen: begin
            round_plan[SelGreen] = hi;
            round_plan[SelRed]   = $urandom_range(0, hi);
            round_plan[SelBlue]  = $urandom_range(0, hi);
          end
          default: begin
            round_plan[SelBlue]  = hi;
            round_plan[SelGreen] = $urandom_range(0, hi - 1);
            round_plan[SelRed]   = $urandom_range(0, hi);
          end
        endcase
      end
    end
    v = 16'(round_plan[accepted_count % 4]);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic drive_sample(input logic [15:0] v, input logic typed, input result_t typed_res);
    result_t r;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (in_stall);
    predict_sample(v, r);
    pending_results.push_back(typed ? typed_res : r);
    accepted_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic apply_setting(input logic [15:0] thr, input logic [RunW-1:0] runs);
    cfg_we <= 1'b1;
    cfg_idx <= RegWhiteThreshold;
    cfg_data <= thr;
    white_thresh_q = thr;
    @(negedge clk);
    cfg_idx <= RegStableRuns;
    cfg_data <= CfgDataW'(runs);
    stable_runs_q = runs;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no pending sample");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (s2 !== exp_r.s2) begin
          $error("select_s2: expected %0d, actual %0d", exp_r.s2, s2);
          error_count++;
        end
        if (s3 !== exp_r.s3) begin
          $error("select_s3: expected %0d, actual %0d", exp_r.s3, s3);
          error_count++;
        end
        if (classified !== exp_r.classified) begin
          $error("classified: expected %0d, actual %0d", exp_r.classified, classified);
          error_count++;
        end
        if (raw_color !== exp_r.raw) begin
          $error("raw_color: expected %0d, actual %0d", exp_r.raw, raw_color);
          error_count++;
        end
        if (verified_color !== exp_r.verified) begin
          $error("verified_color: expected %0d, actual %0d", exp_r.verified, verified_color);
          error_count++;
        end
        if (exp_r.classified) round_count++;
        if (exp_r.verified != last_verified) verified_changes++;
        last_verified = exp_r.verified;
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [15:0]     v;
    logic [15:0]     thr;
    logic [RunW-1:0] runs;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    filt_sel_q = SelClear;
    for (int i = 0; i < 4; i++) filt_count_q[i] = '0;
    cand_color_q = ColorWhite;
    run_len_q = '0;
    stable_color_q = ColorWhite;
    last_verified = ColorWhite;
    white_thresh_q = WhiteThresholdReset;
    stable_runs_q = StableRunsReset;
    target_color = ColorGreen;
    accepted_count = 0;
    error_count = 0;
    round_count = 0;
    verified_changes = 0;
    setting_count = 1;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // Rounds cover both count extremes, the threshold edge and compare ties.
    directed_rows = '{
      {16'd0,     1'b1, {1'b1, 1'b1, 1'b0, ColorWhite, ColorWhite}},
      {16'hFFFF,  1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd0,     1'b1, {1'b1, 1'b0, 1'b1, ColorGreen, ColorWhite}},
      {16'hFFFF,  1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'hFFFF,  1'b0, NoRes},
      {16'd0,     1'b1, {1'b1, 1'b0, 1'b1, ColorWhite, ColorWhite}},
      {16'd100,   1'b0, NoRes},
      {16'd5,     1'b0, NoRes},
      {16'd6,     1'b0, NoRes},
      {16'd6,     1'b0, NoRes},
      {16'd101,   1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd7,     1'b0, NoRes},
      {16'd8,     1'b0, NoRes},
      {16'd7,     1'b0, NoRes},
      {16'd0,     1'b0, NoRes},
      {16'd9,     1'b0, NoRes},
      {16'd9,     1'b0, NoRes},
      {16'd9,     1'b0, NoRes}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirectedRows; i++) begin
      drive_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin thr = 16'd0;     runs = 4'd0;  end
        1: begin thr = 16'hFFFF;  runs = 4'd15; end
        3: begin thr = 16'd1000;  runs = 4'd1;  end
        4: begin thr = 16'hFFFF;  runs = 4'd0;  end
        6: begin thr = 16'd0;     runs = 4'd15; end
        7: begin thr = WhiteThresholdReset; runs = StableRunsReset; end
        default: begin
          thr = 16'($urandom_range(0, 65535));
          runs = 4'($urandom_range(0, 15));
        end
      endcase
      if (p == NumPhases - 1) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      drain_results();
      apply_setting(thr, runs);
      for (int k = 0; k < PhaseItems; k++) begin
        if (p == 2 && k == PhaseItems / 2) drain_results();
        pick_sample(v);
        drive_sample(v, 1'b0, NoRes);
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    $display("Checked %0d samples over %0d register settings: %0d classified rounds,",
             accepted_count, setting_count, round_count);
    $display("%0d verified color changes.", verified_changes);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
